/* src/shared_dual_stack_macros.svh */
// Assertion macros used by the checker module.
`ifndef SHARED_DUAL_STACK_MACROS_SVH
`define SHARED_DUAL_STACK_MACROS_SVH

// Implication checked on every rising edge of clk while rst_n is high.
`define SDS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shared_dual_stack: property violated");

// Condition that must never hold at a rising edge of clk.
`define SDS_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("shared_dual_stack: forbidden condition seen");

`endif

/* src/sds_pkg.sv */
`timescale 1ns / 1ps

package sds_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int TOTAL_W = 8;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CMD_W-1:0]         cmd_t;
    typedef logic [TOTAL_W-1:0]       total_t;
    typedef logic [PTR_W-1:0]         ptr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [ADDR_W-1:0]        addr_t;

    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_BACK   = 3'd3;
    localparam cmd_t CMD_PEEK_FRONT = 3'd4;
    localparam cmd_t CMD_PEEK_BACK  = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic rd_en;
        logic rd_back;
        logic load;
        logic res_ok;
        logic res_rd;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic front_empty;
        logic back_empty;
    } stat_t;

endpackage

/* src/sds_if.sv */
`timescale 1ns / 1ps

interface sds_req_if;
    import sds_pkg::*;

    logic  valid;
    logic  ready;
    cmd_t  cmd;
    word_t push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface sds_rsp_if;
    import sds_pkg::*;

    logic   valid;
    logic   ready;
    logic   ok;
    word_t  read_value;
    logic   front_is_empty;
    logic   back_is_empty;
    total_t total_count;

    modport source (output valid, output ok, output read_value, output front_is_empty,
                    output back_is_empty, output total_count, input ready);
    modport sink   (input valid, input ok, input read_value, input front_is_empty,
                    input back_is_empty, input total_count, output ready);
endinterface

/* src/sds_ctrl.sv */
`timescale 1ns / 1ps

module sds_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  sds_pkg::cmd_t  req_cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  sds_pkg::stat_t st,
    output sds_pkg::ctrl_t ctl
);
    import sds_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ok_reg, ok_next;
    logic       rd_reg, rd_next;
    logic       accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_OUT);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        ok_next    = ok_reg;
        rd_next    = rd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ok_next = 1'b0;
                    rd_next = 1'b0;
                    unique case (req_cmd)
                        CMD_PUSH_FRONT:
                        begin
                            ok_next        = !st.full;
                            ctl.push_front = !st.full;
                        end
                        CMD_PUSH_BACK:
                        begin
                            ok_next       = !st.full;
                            ctl.push_back = !st.full;
                        end
                        CMD_POP_FRONT:
                        begin
                            ok_next       = !st.front_empty;
                            rd_next       = !st.front_empty;
                            ctl.pop_front = !st.front_empty;
                            ctl.rd_en     = !st.front_empty;
                        end
                        CMD_POP_BACK:
                        begin
                            ok_next      = !st.back_empty;
                            rd_next      = !st.back_empty;
                            ctl.pop_back = !st.back_empty;
                            ctl.rd_en    = !st.back_empty;
                            ctl.rd_back  = 1'b1;
                        end
                        CMD_PEEK_FRONT:
                        begin
                            ok_next   = !st.front_empty;
                            rd_next   = !st.front_empty;
                            ctl.rd_en = !st.front_empty;
                        end
                        CMD_PEEK_BACK:
                        begin
                            ok_next     = !st.back_empty;
                            rd_next     = !st.back_empty;
                            ctl.rd_en   = !st.back_empty;
                            ctl.rd_back = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // Memory read data is valid here; capture it with the updated flags.
                ctl.load   = 1'b1;
                ctl.res_ok = ok_reg;
                ctl.res_rd = rd_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ok_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            rd_reg    <= rd_next;
        end
    end

endmodule

/* src/sds_datapath.sv */
`timescale 1ns / 1ps

module sds_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  sds_pkg::ctrl_t ctl,
    output sds_pkg::stat_t st,
    input  sds_pkg::word_t push_value,
    output logic           ok,
    output sds_pkg::word_t read_value,
    output logic           front_is_empty,
    output logic           back_is_empty,
    output sds_pkg::total_t total_count
);
    import sds_pkg::*;

    localparam ptr_t DEPTH_P = PTR_W'(DEPTH);

    word_t mem [DEPTH];
    word_t mem_q;

    ptr_t  front_top_reg, front_top_next;
    ptr_t  back_top_reg, back_top_next;
    cnt_t  count_reg, count_next;
    ptr_t  front_below;
    ptr_t  back_below;
    addr_t rd_addr;
    logic [CNT_W+TOTAL_W-1:0] count_ext;

    logic   ok_reg;
    word_t  read_value_reg;
    logic   front_empty_reg;
    logic   back_empty_reg;
    total_t total_reg;

    assign front_below = front_top_reg - ptr_t'(1);
    assign back_below  = back_top_reg - ptr_t'(1);

    assign st.full        = (front_top_reg >= back_top_reg);
    assign st.front_empty = (front_top_reg == '0);
    assign st.back_empty  = (back_top_reg >= DEPTH_P);

    assign rd_addr = ctl.rd_back ? back_top_reg[ADDR_W-1:0] : front_below[ADDR_W-1:0];

    always_comb
    begin
        front_top_next = front_top_reg;
        back_top_next  = back_top_reg;
        count_next     = count_reg;
        if (ctl.push_front)
        begin
            front_top_next = front_top_reg + ptr_t'(1);
        end
        if (ctl.pop_front)
        begin
            front_top_next = front_below;
        end
        if (ctl.push_back)
        begin
            back_top_next = back_below;
        end
        if (ctl.pop_back)
        begin
            back_top_next = back_top_reg + ptr_t'(1);
        end
        if (ctl.push_front || ctl.push_back)
        begin
            count_next = count_reg + cnt_t'(1);
        end
        if (ctl.pop_front || ctl.pop_back)
        begin
            count_next = count_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_top_reg <= '0;
            back_top_reg  <= DEPTH_P;
            count_reg     <= '0;
        end
        else
        begin
            front_top_reg <= front_top_next;
            back_top_reg  <= back_top_next;
            count_reg     <= count_next;
        end
    end

    // Word store with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.push_front)
        begin
            mem[front_top_reg[ADDR_W-1:0]] <= push_value;
        end
        else if (ctl.push_back)
        begin
            mem[back_below[ADDR_W-1:0]] <= push_value;
        end
        if (ctl.rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    assign count_ext = {{TOTAL_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ok_reg          <= ctl.res_ok;
            read_value_reg  <= ctl.res_rd ? mem_q : '0;
            front_empty_reg <= st.front_empty;
            back_empty_reg  <= st.back_empty;
            total_reg       <= count_ext[TOTAL_W-1:0];
        end
    end

    assign ok             = ok_reg;
    assign read_value     = read_value_reg;
    assign front_is_empty = front_empty_reg;
    assign back_is_empty  = back_empty_reg;
    assign total_count    = total_reg;

endmodule

/* src/shared_dual_stack.sv */
// Two stacks sharing one word store, front growing up and back growing down.
// After a request is accepted, the registered memory read and then the output register are loaded
// before the result is shown; the controller holds one request at a time and takes no new request
// until its result has been taken.
// Reset: rst_n is asynchronous and active low; it empties both stacks, and the store is
// left uninitialized because no entry is read before it is written.
`timescale 1ns / 1ps

module shared_dual_stack (
    input  logic      clk,
    input  logic      rst_n,
    sds_req_if.sink   req,
    sds_rsp_if.source rsp
);
    import sds_pkg::*;

    ctrl_t ctl;
    stat_t st;

    sds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_cmd   (req.cmd),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .ctl       (ctl)
    );

    sds_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .st             (st),
        .push_value     (req.push_value),
        .ok             (rsp.ok),
        .read_value     (rsp.read_value),
        .front_is_empty (rsp.front_is_empty),
        .back_is_empty  (rsp.back_is_empty),
        .total_count    (rsp.total_count)
    );

endmodule

/* src/sds_checker.sv */
`timescale 1ns / 1ps
`include "shared_dual_stack_macros.svh"

module sds_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input logic            rsp_ok,
    input sds_pkg::word_t  rsp_read_value,
    input logic            rsp_front_is_empty,
    input logic            rsp_back_is_empty,
    input sds_pkg::total_t rsp_total_count
);
    import sds_pkg::*;

    // A result that is not taken stays offered.
    `SDS_ASSERT_IMPL(a_rsp_hold, rsp_valid && !rsp_ready, ##1 rsp_valid)
    // Only one item is in flight, so a request is never taken while a result waits.
    `SDS_ASSERT_NEVER(a_one_in_flight, req_ready && rsp_valid)
    // Every accepted request is followed by its result, after the controller's load state.
    `SDS_ASSERT_IMPL(a_latency, req_valid && req_ready, ##2 rsp_valid)
    // Both stacks empty means nothing is held.
    `SDS_ASSERT_IMPL(a_empty_count,
                     rsp_valid && rsp_front_is_empty && rsp_back_is_empty,
                     rsp_total_count == '0)
    // A failed command returns a zero word.
    `SDS_ASSERT_IMPL(a_fail_zero, rsp_valid && !rsp_ok, rsp_read_value == '0)

endmodule

bind shared_dual_stack sds_checker u_sds_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_ok             (rsp.ok),
    .rsp_read_value     (rsp.read_value),
    .rsp_front_is_empty (rsp.front_is_empty),
    .rsp_back_is_empty  (rsp.back_is_empty),
    .rsp_total_count    (rsp.total_count)
);
